// ===== hdl/firc_pkg.sv =====
package firc_pkg;

   localparam int DEF_MAX_TAPS = 16;
   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 16;
   localparam int PROD_W       = SAMPLE_W + COEF_W;
   localparam int ACC_W        = 36;
   localparam int TAP_CNT_W    = 5;
   localparam int IDX_W        = 4;

   localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = TAP_CNT_W'(16);

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_COEF   = 1'b1
   } firc_cmd_type;

   typedef struct packed {
      firc_cmd_type               command;
      logic [IDX_W-1:0]           coef_index;
      logic signed [SAMPLE_W-1:0] value;
   } firc_req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] filtered;
   } firc_rsp_type;

   typedef struct packed {
      logic prod_load;
      logic sum_load;
      logic clear;
   } firc_ctrl_type;

endpackage

// ===== hdl/firc_stream_if.sv =====
interface firc_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/firc_cell.sv =====
module firc_cell
   import firc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  firc_ctrl_type              ctrl,
   input  logic                       active,
   input  logic                       coef_we,
   input  logic signed [SAMPLE_W-1:0] value,
   input  logic signed [ACC_W-1:0]    sum_next,
   output logic signed [ACC_W-1:0]    sum_out
);

   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  sum_ff, sum_in;

   always_comb begin
      coef_in = coef_ff;
      if (coef_we) begin
         coef_in = COEF_W'(value);
      end
   end

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.prod_load) begin
         prod_in = active ? PROD_W'(coef_ff * value) : '0;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.sum_load) begin
         sum_in = ACC_W'(prod_ff) + sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         sum_ff  <= '0;
      end else begin
         coef_ff <= coef_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign sum_out = sum_ff;

endmodule

// ===== hdl/fir_filter_circular.sv =====
// Channel   Dir  Payload                          Handshake
// req_chan  in   command, coef_index, value       valid/ready
// rsp_chan  out  filtered (Q6.30, 36 bits)        valid/ready
// csr       in   tap_count (5 bits)               csr_write_en, no wait
//
// One request per cycle sustained while rsp_chan takes results; a result is valid once its request
// has passed the product stage, then the partial-sum stage of the cell row.
// Reset: coefficients and partial sums zero, tap count 16.
// A pending result holds the sum stage; the product stage holds one more request.
// Coefficient and tap-count writes zero the partial sums of every cell.
module fir_filter_circular
   import firc_pkg::*;
#(
   parameter int MAX_TAPS = DEF_MAX_TAPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [TAP_CNT_W-1:0] csr_write_data,
   firc_stream_if.sink          req_chan,
   firc_stream_if.source        rsp_chan
);

   logic [TAP_CNT_W-1:0] tap_cnt_ff, tap_cnt_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_clear_ff, s1_clear_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   firc_req_type  req;
   firc_ctrl_type ctrl;
   logic          req_fire;
   logic          req_ready;
   logic          s1_adv;
   logic          coef_ok;

   logic                    active [MAX_TAPS];
   logic                    coef_we [MAX_TAPS];
   logic signed [ACC_W-1:0] sum_chain [MAX_TAPS+1];

   assign req       = req_chan.data;
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_chan.valid && req_ready;
   assign coef_ok   = 32'(req.coef_index) < 32'(MAX_TAPS);

   assign req_chan.ready = req_ready;

   always_comb begin
      tap_cnt_in = tap_cnt_ff;
      if (csr_write_en) begin
         tap_cnt_in = csr_write_data;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_clear_in = s1_clear_ff;
      if (req_fire && req.command == CMD_SAMPLE) begin
         s1_valid_in = 1'b1;
         s1_clear_in = 1'b0;
      end else if (req_fire && req.command == CMD_COEF && coef_ok) begin
         s1_valid_in = 1'b1;
         s1_clear_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && !s1_clear_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      ctrl.prod_load = req_fire && req.command == CMD_SAMPLE;
      ctrl.sum_load  = s1_adv && !s1_clear_ff;
      ctrl.clear     = (s1_adv && s1_clear_ff) || csr_write_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_cnt_ff   <= TAP_CNT_RESET;
         s1_valid_ff  <= 1'b0;
         s1_clear_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_cnt_ff   <= tap_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s1_clear_ff  <= s1_clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sum_chain[MAX_TAPS] = '0;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      assign active[k]  = (k == 0) || (32'(tap_cnt_ff) > 32'(k));
      assign coef_we[k] = req_fire && req.command == CMD_COEF &&
                          (32'(req.coef_index) == 32'(k));

      firc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .active   (active[k]),
         .coef_we  (coef_we[k]),
         .value    (req.value),
         .sum_next (sum_chain[k+1]),
         .sum_out  (sum_chain[k])
      );
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data.filtered = sum_chain[0];

   a_hold_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !ctrl.sum_load)
      else $error("sum stage advanced over a pending result");

   a_coef_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.command == CMD_COEF && coef_ok) |=> (s1_valid_ff && s1_clear_ff))
      else $error("coefficient write did not queue a history clear");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (sum_chain[0] == '0))
      else $error("partial sums not cleared");

   a_idle_tail: assert property (@(posedge clock) disable iff (reset)
      !active[MAX_TAPS-1] |-> (sum_chain[MAX_TAPS-1] == '0))
      else $error("inactive cell holds a nonzero partial sum");

endmodule

// ===== tb/tb_fir_filter_circular.sv =====
`timescale 1ns / 100ps

module tb_fir_filter_circular
   import firc_pkg::*;
();

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_CYCLES  = 4;
   localparam int PRINT_CAP    = 40;
   localparam int N_ROWS       = 25;

   typedef struct packed {
      firc_cmd_type            command;
      logic [IDX_W-1:0]        coef_index;
      logic signed [SAMPLE_W-1:0] value;
      logic                    fixed;
      logic signed [ACC_W-1:0] sum;
   } step_row_type;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_PATTERN,
      FLOW_RANDOM,
      FLOW_SLOW
   } flow_mode_type;

   localparam step_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{CMD_SAMPLE, 4'd0,  16'sd32767,  1'b1, 36'sd0},
      '{CMD_SAMPLE, 4'd5,  -16'sd32768, 1'b1, 36'sd0},
      '{CMD_SAMPLE, 4'd10, 16'sd21845,  1'b1, 36'sd0},
      '{CMD_COEF,   4'd0,  -16'sd32768, 1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd32768, 1'b1, 36'sd1073741824},
      '{CMD_SAMPLE, 4'd15, 16'sd32767,  1'b1, -36'sd1073709056},
      '{CMD_COEF,   4'd15, 16'sd32767,  1'b0, 36'sd0},
      '{CMD_COEF,   4'd1,  -16'sd1,     1'b0, 36'sd0},
      '{CMD_COEF,   4'd10, 16'sd10922,  1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd1,      1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd1,     1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd32767,  1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd32768, 1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd0,      1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd12345,  1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd23456, 1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd32767,  1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd32767,  1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd32768, 1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd100,    1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd100,   1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd21845,  1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd21846, 1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  16'sd7,      1'b0, 36'sd0},
      '{CMD_SAMPLE, 4'd0,  -16'sd32768, 1'b0, 36'sd0}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [TAP_CNT_W-1:0] csr_write_data;

   firc_stream_if #(.payload_type(firc_req_type)) req_if ();
   firc_stream_if #(.payload_type(firc_rsp_type)) rsp_if ();

   logic signed [COEF_W-1:0]   coef_bank   [DEF_MAX_TAPS];
   logic signed [SAMPLE_W-1:0] sample_ring [DEF_MAX_TAPS];
   int                         ring_pos;
   logic [TAP_CNT_W-1:0]       tap_setting;
   logic signed [ACC_W-1:0]    pending_sums [$];

   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   int            flow_left = 0;
   flow_mode_type flow_mode = FLOW_FREE;
   logic [31:0]   flow_pattern = '1;

   fir_filter_circular u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == LIMIT_CYCLES);
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   task automatic clear_ring();
      for (int i = 0; i < DEF_MAX_TAPS; i++) begin
         sample_ring[i] = '0;
      end
      ring_pos = 0;
   endtask

   function automatic logic signed [ACC_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] x
   );
      int                      n;
      int                      pos;
      int                      slot;
      logic signed [PROD_W-1:0] prod;
      logic signed [ACC_W-1:0] acc;
      if (tap_setting == 0) begin
         n = 1;
      end else if (tap_setting > DEF_MAX_TAPS) begin
         n = DEF_MAX_TAPS;
      end else begin
         n = int'(tap_setting);
      end
      pos = (ring_pos >= n) ? 0 : ring_pos;
      sample_ring[pos] = x;
      acc = '0;
      for (int k = 0; k < n; k++) begin
         slot = (pos + n - k) % n;
         prod = coef_bank[k] * sample_ring[slot];
         acc = acc + prod;
      end
      pos++;
      ring_pos = (pos >= n) ? 0 : pos;
      return acc;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_value(input bit edgy);
      logic signed [SAMPLE_W-1:0] v;
      v = SAMPLE_W'($urandom);
      if (edgy) begin
         case ($urandom_range(0, 4))
            0: v = -16'sd32768;
            1: v = 16'sd32767;
            2: v = -16'sd1;
            3: v = 16'sd0;
            default: ;
         endcase
      end
      return v;
   endfunction

   task automatic send_request(
      input firc_req_type            req,
      input logic                    fixed,
      input logic signed [ACC_W-1:0] fixed_sum
   );
      logic signed [ACC_W-1:0] sum;
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid = 1'b1;
      req_if.data  = req;
      do @(posedge clock); while (!req_if.ready);
      if (req.command == CMD_COEF) begin
         coef_bank[req.coef_index] = req.value;
         clear_ring();
      end else begin
         sum = filter_sample(req.value);
         pending_sums.push_back(fixed ? fixed_sum : sum);
      end
      @(negedge clock);
   endtask

   task automatic set_tap_count(input logic [TAP_CNT_W-1:0] taps);
      req_if.valid = 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = taps;
      @(negedge clock);
      csr_write_en = 1'b0;
      tap_setting  = taps;
      clear_ring();
      burst_left = 0;
   endtask

   // hold the response ready line on a pattern of its own
   always @(negedge clock) begin
      if (flow_left == 0) begin
         flow_mode    = flow_mode_type'($urandom_range(0, 3));
         flow_left    = $urandom_range(4, 64);
         flow_pattern = $urandom;
      end
      flow_left--;
      case (flow_mode)
         FLOW_FREE: begin
            rsp_if.ready = 1'b1;
         end
         FLOW_PATTERN: begin
            rsp_if.ready = flow_pattern[0];
            flow_pattern = {flow_pattern[0], flow_pattern[31:1]};
         end
         FLOW_RANDOM: begin
            rsp_if.ready = ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_if.ready = (flow_left % 5 == 0);
         end
      endcase
   end

   always @(posedge clock) begin : check_results
      logic signed [ACC_W-1:0] want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected result filtered=%0d",
                                      rsp_if.data.filtered));
         end else begin
            want = pending_sums.pop_front();
            if (rsp_if.data.filtered !== want) begin
               report_mismatch($sformatf("filtered: expected %0d, got %0d",
                                         want, rsp_if.data.filtered));
            end
         end
      end
   end

   initial begin : stimulus
      firc_req_type         req;
      logic [TAP_CNT_W-1:0] taps;
      int                   random_sent;
      int                   phase;
      int                   n_coef;
      int                   n_samples;
      bit                   full_load;
      bit                   edgy;

      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      tap_setting    = TAP_CNT_RESET;
      for (int i = 0; i < DEF_MAX_TAPS; i++) begin
         coef_bank[i] = '0;
      end
      clear_ring();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         req.command    = DIRECTED_ROWS[r].command;
         req.coef_index = DIRECTED_ROWS[r].coef_index;
         req.value      = DIRECTED_ROWS[r].value;
         send_request(req, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].sum);
      end

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase)
            0: taps = 5'd0;
            1: taps = 5'd31;
            2: taps = 5'd1;
            3: taps = 5'd16;
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  taps = TAP_CNT_W'($urandom_range(0, 31));
               end else begin
                  taps = TAP_CNT_W'($urandom_range(1, 16));
               end
            end
         endcase
         set_tap_count(taps);

         full_load = (phase == 1) || ($urandom_range(0, 7) == 0);
         edgy      = ($urandom_range(0, 3) == 0);
         n_coef    = full_load ? DEF_MAX_TAPS : $urandom_range(0, 4);
         for (int i = 0; i < n_coef; i++) begin
            req.command    = CMD_COEF;
            req.coef_index = full_load ? IDX_W'(i) : IDX_W'($urandom_range(0, 15));
            req.value      = (full_load && edgy) ? -16'sd32768 : pick_value(edgy);
            send_request(req, 1'b0, '0);
            random_sent++;
         end

         n_samples = $urandom_range(1, 60);
         for (int i = 0; i < n_samples; i++) begin
            if ($urandom_range(0, 49) == 0) begin
               req.command = CMD_COEF;
            end else begin
               req.command = CMD_SAMPLE;
            end
            req.coef_index = IDX_W'($urandom);
            if (full_load && edgy) begin
               req.value = ($urandom_range(0, 7) == 0) ? 16'sd32767 : -16'sd32768;
            end else begin
               req.value = pick_value(edgy);
            end
            send_request(req, 1'b0, '0);
            random_sent++;
         end
         phase++;
      end

      req_if.valid = 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
